>>> rtl/core/wed_pkg.sv
package wed_pkg;

   // SCSI operation codes
   localparam logic [7:0] OP_WRITE6       = 8'h0A;
   localparam logic [7:0] OP_WRITE10      = 8'h2A;
   localparam logic [7:0] OP_WRITE_VER10  = 8'h2E;
   localparam logic [7:0] OP_WRITE_SAME10 = 8'h41;
   localparam logic [7:0] OP_UNMAP        = 8'h42;
   localparam logic [7:0] OP_WRITE12      = 8'hAA;
   localparam logic [7:0] OP_WRITE_VER12  = 8'hAE;
   localparam logic [7:0] OP_WRITE16      = 8'h8A;
   localparam logic [7:0] OP_WRITE_VER16  = 8'h8E;
   localparam logic [7:0] OP_WRITE_SAME16 = 8'h93;
   localparam logic [7:0] OP_ATA_PT16     = 8'h85;
   localparam logic [7:0] OP_ATA_PT12     = 8'hA1;

   // minimum command block lengths
   localparam logic [7:0] LEN_CDB6  = 8'd6;
   localparam logic [7:0] LEN_CDB10 = 8'd10;
   localparam logic [7:0] LEN_CDB12 = 8'd12;
   localparam logic [7:0] LEN_CDB16 = 8'd16;

   // pass-through protocols that move data out
   localparam logic [3:0] PROTO_PIO_OUT = 4'd5;
   localparam logic [3:0] PROTO_DMA     = 4'd7;

   // ATA commands
   localparam logic [7:0] ATA_WRITE_DMA        = 8'hCA;
   localparam logic [7:0] ATA_WRITE_DMA_EXT    = 8'h35;
   localparam logic [7:0] ATA_WRITE_DMA_QUEUED = 8'hCC;
   localparam logic [7:0] ATA_WRITE_DMA_Q_EXT  = 8'h36;
   localparam logic [7:0] ATA_WRITE_FPDMA      = 8'h61;
   localparam logic [7:0] ATA_WRITE_SECTORS    = 8'h30;
   localparam logic [7:0] ATA_WRITE_SECT_EXT   = 8'h34;
   localparam logic [7:0] ATA_WRITE_STREAM_DMA = 8'h3C;
   localparam logic [7:0] ATA_WRITE_MULT_EXT   = 8'h24;
   localparam logic [7:0] ATA_SECURITY_ERASE   = 8'hF4;
   localparam logic [7:0] ATA_DOWNLOAD_UCODE   = 8'h92;
   localparam logic [7:0] ATA_DOWNLOAD_UCODE_D = 8'h93;

   localparam logic [63:0] COUNT_WHOLE = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        is_write;
      logic [63:0] start_sector;
      logic [63:0] sector_count;
   } extent_type;

endpackage

>>> rtl/core/write_extent_decoder.sv
// channel   ports                                                  direction
// request   req_valid/req_stall, req_mode, req_cdb_bytes_lo/hi,    in
//           req_cdb_length, req_current_taskfile, req_previous_taskfile
// response  rsp_valid/rsp_stall, rsp_is_write, rsp_start_sector,   out
//           rsp_sector_count
//
// One request per cycle sustained while rsp_stall is low; an accepted request
// reaches rsp_valid through the input register, decode and result register.
// Synchronous active-high reset empties both stages; data registers are not reset.
// A stalled response holds in the result register while the input register
// still takes a request; req_stall rises only when both stages are full and
// rsp_stall is high.
module write_extent_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [63:0] req_cdb_bytes_lo,
   input  logic [63:0] req_cdb_bytes_hi,
   input  logic [7:0]  req_cdb_length,
   input  logic [63:0] req_current_taskfile,
   input  logic [63:0] req_previous_taskfile,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_write,
   output logic [63:0] rsp_start_sector,
   output logic [63:0] rsp_sector_count
);
   import wed_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        req_accept, s2_load;

   logic        mode_ff;
   logic [63:0] cdb_lo_ff, cdb_hi_ff;
   logic [7:0]  cdb_len_ff;
   logic [63:0] cur_tf_ff, prev_tf_ff;

   extent_type  result_ff, result_in;
   extent_type  scsi_res, ata_res;

   logic [7:0]  cdb [16];
   logic [7:0]  cur [8];
   logic [7:0]  prev [8];
   logic [3:0]  proto;
   logic        proto_out;
   logic [15:0] count16;

   // pipeline control
   assign s2_load     = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !s2_load;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff    <= req_mode;
         cdb_lo_ff  <= req_cdb_bytes_lo;
         cdb_hi_ff  <= req_cdb_bytes_hi;
         cdb_len_ff <= req_cdb_length;
         cur_tf_ff  <= req_current_taskfile;
         prev_tf_ff <= req_previous_taskfile;
      end
      if (s2_load) begin
         result_ff <= result_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         cdb[i]     = cdb_lo_ff[8*i +: 8];
         cdb[i + 8] = cdb_hi_ff[8*i +: 8];
         cur[i]     = cur_tf_ff[8*i +: 8];
         prev[i]    = prev_tf_ff[8*i +: 8];
      end
   end

   assign proto     = cdb[1][4:1];
   assign proto_out = (proto == PROTO_PIO_OUT) || (proto == PROTO_DMA);

   // SCSI command block decode
   always_comb begin
      scsi_res = '0;
      case (cdb[0])
         OP_WRITE6: begin
            if (cdb_len_ff >= LEN_CDB6) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.start_sector = {43'd0, cdb[1][4:0], cdb[2], cdb[3]};
               scsi_res.sector_count = (cdb[4] == 8'd0) ? 64'd256 : {56'd0, cdb[4]};
            end
         end
         OP_WRITE10, OP_WRITE_VER10, OP_WRITE_SAME10: begin
            if (cdb_len_ff >= LEN_CDB10) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.start_sector = {32'd0, cdb[2], cdb[3], cdb[4], cdb[5]};
               scsi_res.sector_count = {48'd0, cdb[7], cdb[8]};
               // zero count on write same runs to the end of the disk
               if (cdb[0] == OP_WRITE_SAME10 && {cdb[7], cdb[8]} == 16'd0) begin
                  scsi_res.sector_count = ~scsi_res.start_sector;
               end
            end
         end
         OP_WRITE12, OP_WRITE_VER12: begin
            if (cdb_len_ff >= LEN_CDB12) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.start_sector = {32'd0, cdb[2], cdb[3], cdb[4], cdb[5]};
               scsi_res.sector_count = {32'd0, cdb[6], cdb[7], cdb[8], cdb[9]};
            end
         end
         OP_WRITE16, OP_WRITE_VER16, OP_WRITE_SAME16: begin
            if (cdb_len_ff >= LEN_CDB16) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.start_sector = {cdb[2], cdb[3], cdb[4], cdb[5],
                                        cdb[6], cdb[7], cdb[8], cdb[9]};
               scsi_res.sector_count = {32'd0, cdb[10], cdb[11], cdb[12], cdb[13]};
               if (cdb[0] == OP_WRITE_SAME16 &&
                   {cdb[10], cdb[11], cdb[12], cdb[13]} == 32'd0) begin
                  scsi_res.sector_count = ~scsi_res.start_sector;
               end
            end
         end
         OP_UNMAP: begin
            scsi_res.is_write     = 1'b1;
            scsi_res.sector_count = COUNT_WHOLE;
         end
         OP_ATA_PT16: begin
            if (cdb_len_ff >= LEN_CDB16 &&
                (proto_out || cdb[14] == ATA_WRITE_SECTORS ||
                 cdb[14] == ATA_WRITE_DMA_EXT || cdb[14] == ATA_WRITE_MULT_EXT)) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.sector_count = COUNT_WHOLE;
            end
         end
         OP_ATA_PT12: begin
            if (cdb_len_ff >= LEN_CDB12 &&
                (proto_out || cdb[9] == ATA_WRITE_SECTORS ||
                 cdb[9] == ATA_WRITE_DMA_EXT || cdb[9] == ATA_WRITE_MULT_EXT)) begin
               scsi_res.is_write     = 1'b1;
               scsi_res.sector_count = COUNT_WHOLE;
            end
         end
         default: begin
            scsi_res = '0;
         end
      endcase
      // an empty block never writes
      if (cdb_len_ff == 8'd0) begin
         scsi_res = '0;
      end
   end

   assign count16 = {prev[1], cur[1]};

   // ATA task file decode
   always_comb begin
      ata_res = '0;
      case (cur[6])
         ATA_WRITE_DMA, ATA_WRITE_DMA_EXT, ATA_WRITE_DMA_QUEUED, ATA_WRITE_DMA_Q_EXT,
         ATA_WRITE_FPDMA, ATA_WRITE_SECTORS, ATA_WRITE_SECT_EXT,
         ATA_WRITE_STREAM_DMA: begin
            ata_res.is_write = 1'b1;
            if (!cur[5][6]) begin
               // CHS addressing: treat as whole device
               ata_res.sector_count = COUNT_WHOLE;
            end else if ((prev[1] | prev[2] | prev[3] | prev[4]) != 8'd0) begin
               ata_res.start_sector = {16'd0, prev[4], prev[3], prev[2],
                                       cur[4], cur[3], cur[2]};
               ata_res.sector_count = (count16 == 16'd0) ? 64'd65536 : {48'd0, count16};
            end else begin
               ata_res.start_sector = {36'd0, cur[5][3:0], cur[4], cur[3], cur[2]};
               ata_res.sector_count = (cur[1] == 8'd0) ? 64'd256 : {56'd0, cur[1]};
            end
         end
         ATA_SECURITY_ERASE, ATA_DOWNLOAD_UCODE, ATA_DOWNLOAD_UCODE_D: begin
            ata_res.is_write     = 1'b1;
            ata_res.sector_count = COUNT_WHOLE;
         end
         default: begin
            ata_res = '0;
         end
      endcase
   end

   assign result_in = mode_ff ? ata_res : scsi_res;

   assign rsp_valid        = s2_valid_ff;
   assign rsp_is_write     = result_ff.is_write;
   assign rsp_start_sector = result_ff.start_sector;
   assign rsp_sector_count = result_ff.sector_count;

   a_not_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_write |-> rsp_start_sector == 64'd0 &&
                                     rsp_sector_count == 64'd0)
      else $error("non-write response carries a nonzero extent");

   a_whole_from_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sector_count == COUNT_WHOLE |-> rsp_start_sector == 64'd0)
      else $error("whole-device count with nonzero start sector");

   a_empty_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !s1_valid_ff && !s2_valid_ff |=> ##1 rsp_valid)
      else $error("request into empty pipeline did not reach response in two cycles");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s2_valid_ff && rsp_stall)
      else $error("request stalled while the result register could drain");

endmodule
